[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is ignored while reset is asserted.
`define DSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define DSC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/dsc_pkg.sv]
// Shared types and constants of the service and component parser.
package dsc_pkg;

    localparam int SEEN_DEPTH  = 64;
    localparam int SEEN_IDX_W  = $clog2(SEEN_DEPTH);
    localparam int SEEN_FILL_W = $clog2(SEEN_DEPTH + 1);
    localparam int ID_W        = 32;

    localparam logic RK_SERVICE   = 1'b0;
    localparam logic RK_COMPONENT = 1'b1;

    typedef struct packed {
        logic            probe;
        logic            commit;
        logic [ID_W-1:0] probe_id;
        logic [ID_W-1:0] commit_id;
    } seen_ctl_t;

    typedef struct packed {
        logic            record_kind;
        logic [ID_W-1:0] service_id;
        logic            local_flag;
        logic [2:0]      access_id;
        logic [3:0]      component_count;
        logic            cycle_complete;
        logic [3:0]      component_index;
        logic [1:0]      transport_mode;
        logic [5:0]      component_type;
        logic [5:0]      subchannel_id;
        logic            secondary_flag;
        logic            ca_flag;
    } rec_t;

endpackage

[rtl/core/dsc_seen_table.sv]
// Table of seen service ids with a registered parallel compare.
module dsc_seen_table (
    input  logic                clk,
    input  logic                rst_n,
    input  dsc_pkg::seen_ctl_t  ctl,
    output logic                hit
);
    import dsc_pkg::*;

    logic [ID_W-1:0]        ids_reg [SEEN_DEPTH];
    logic [SEEN_DEPTH-1:0]  valid_reg;
    logic [SEEN_DEPTH-1:0]  valid_next;
    logic [SEEN_DEPTH-1:0]  match_reg;
    logic [SEEN_DEPTH-1:0]  match_next;
    logic [SEEN_FILL_W-1:0] fill_reg;
    logic [SEEN_FILL_W-1:0] fill_next;
    logic [SEEN_FILL_W-1:0] fill_base;
    logic [SEEN_IDX_W-1:0]  wr_idx;
    logic                   wr_en;

    // Compare every live entry against the id as it is being assembled.
    always_comb
    begin
        for (int i = 0; i < SEEN_DEPTH; i++)
        begin
            match_next[i] = valid_reg[i] && (ids_reg[i] == ctl.probe_id);
        end
    end

    assign hit = |match_reg;

    always_comb
    begin
        valid_next = valid_reg;
        fill_next  = fill_reg;
        wr_en      = 1'b0;
        fill_base  = hit ? '0 : fill_reg;
        wr_idx     = fill_base[SEEN_IDX_W-1:0];
        if (ctl.commit)
        begin
            // Drop all entries on a repeat, then record the id if room is left.
            if (hit)
            begin
                valid_next = '0;
            end
            if (fill_base < SEEN_FILL_W'(SEEN_DEPTH))
            begin
                wr_en              = 1'b1;
                valid_next[wr_idx] = 1'b1;
                fill_next          = fill_base + SEEN_FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= '0;
            match_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
            if (ctl.probe)
            begin
                match_reg <= match_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ids_reg[wr_idx] <= ctl.commit_id;
        end
    end

endmodule

[rtl/core/dsc_field_parser.sv]
// Byte-level parse state and result formation for service entries.
module dsc_field_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [7:0]         byte_value,
    input  logic               start_of_field,
    input  logic               long_ids,
    input  logic               hit,
    output logic               res_valid,
    output dsc_pkg::rec_t      res,
    output dsc_pkg::seen_ctl_t seen_ctl
);
    import dsc_pkg::*;

    typedef enum logic [1:0] {PH_ID, PH_HDR, PH_D0, PH_D1} phase_t;

    phase_t          phase_reg, phase_next, phase_eff;
    logic [1:0]      bidx_reg, bidx_next, bidx_eff;
    logic [ID_W-1:0] acc_reg, acc_next, acc_base, acc_shift, acc_final;
    logic [3:0]      left_reg, left_next, left_eff, left_dec;
    logic [3:0]      pos_reg, pos_next, pos_eff;
    logic [7:0]      fdb_reg, fdb_next;
    logic            id_done;

    // A start marker drops any partial entry.
    assign phase_eff = start_of_field ? PH_ID : phase_reg;
    assign bidx_eff  = start_of_field ? 2'd0 : bidx_reg;
    assign left_eff  = start_of_field ? 4'd0 : left_reg;
    assign pos_eff   = start_of_field ? 4'd0 : pos_reg;
    assign left_dec  = left_eff - 4'd1;

    assign acc_base  = (bidx_eff == 2'd0) ? '0 : acc_reg;
    assign acc_shift = {acc_base[ID_W-9:0], byte_value};
    assign id_done   = long_ids ? (bidx_eff == 2'd3) : (bidx_eff != 2'd0);
    assign acc_final = (id_done && !long_ids) ? {16'h0000, acc_shift[15:0]} : acc_shift;

    always_comb
    begin
        phase_next         = phase_reg;
        bidx_next          = bidx_reg;
        acc_next           = acc_reg;
        left_next          = left_reg;
        pos_next           = pos_reg;
        fdb_next           = fdb_reg;
        res_valid          = 1'b0;
        res                = '0;
        seen_ctl           = '0;
        seen_ctl.probe_id  = acc_final;
        seen_ctl.commit_id = acc_reg;
        if (advance)
        begin
            bidx_next = bidx_eff;
            left_next = left_eff;
            pos_next  = pos_eff;
            case (phase_eff)
                PH_ID:
                begin
                    acc_next       = acc_final;
                    seen_ctl.probe = 1'b1;
                    if (id_done)
                    begin
                        bidx_next  = 2'd0;
                        phase_next = PH_HDR;
                    end
                    else
                    begin
                        bidx_next  = bidx_eff + 2'd1;
                        phase_next = PH_ID;
                    end
                end
                PH_HDR:
                begin
                    seen_ctl.commit     = 1'b1;
                    res_valid           = 1'b1;
                    res.record_kind     = RK_SERVICE;
                    res.service_id      = acc_reg;
                    res.local_flag      = byte_value[7];
                    res.access_id       = byte_value[6:4];
                    res.component_count = byte_value[3:0];
                    res.cycle_complete  = hit;
                    left_next           = byte_value[3:0];
                    pos_next            = 4'd0;
                    phase_next          = (byte_value[3:0] != 4'd0) ? PH_D0 : PH_ID;
                end
                PH_D0:
                begin
                    fdb_next   = byte_value;
                    phase_next = PH_D1;
                end
                PH_D1:
                begin
                    res_valid           = 1'b1;
                    res.record_kind     = RK_COMPONENT;
                    res.service_id      = acc_reg;
                    res.component_index = pos_eff;
                    res.transport_mode  = fdb_reg[7:6];
                    res.component_type  = fdb_reg[5:0];
                    res.subchannel_id   = byte_value[7:2];
                    res.secondary_flag  = byte_value[1];
                    res.ca_flag         = byte_value[0];
                    pos_next            = pos_eff + 4'd1;
                    left_next           = left_dec;
                    phase_next          = (left_dec != 4'd0) ? PH_D0 : PH_ID;
                end
                default:
                begin
                    phase_next = PH_ID;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ID;
            bidx_reg  <= '0;
            acc_reg   <= '0;
            left_reg  <= '0;
            pos_reg   <= '0;
            fdb_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            bidx_reg  <= bidx_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            fdb_reg   <= fdb_next;
        end
    end

endmodule

[rtl/core/dab_service_component_parser_core.sv]
// Top level of the service and component definition parser.
//
// Input channel: one body byte per transaction on in_valid / in_ready, with
// start_of_field marking the first body byte of a field and long_ids
// selecting 32-bit (data) or 16-bit (programme) service ids for that byte.
// Output channel: out_valid / out_ready carries one record per service
// header byte (record_kind 0) and one per component descriptor (kind 1).
// Id and descriptor bytes that only build state produce no transaction.
// An accepted byte lands in the input register, is parsed from there once
// the output register is free or emptying, and its record is loaded into
// the output register, which drives out_valid.
// Throughput: one byte per cycle while the receiver takes records; the
// seen-id compare runs on the cycle of the final id byte and is registered
// for the header byte, so all 64 table entries are checked in parallel.
// When the receiver stalls the record holds in the output register, the
// byte behind it holds in the input register, and in_ready drops.
// Reset clears the parse state, empties both registers and marks every
// table entry unused; no clearing pass is needed, bytes flow right away.
module dab_service_component_parser_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              byte_value,
    input  logic                    start_of_field,
    input  logic                    long_ids,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    record_kind,
    output logic [dsc_pkg::ID_W-1:0] service_id,
    output logic                    local_flag,
    output logic [2:0]              access_id,
    output logic [3:0]              component_count,
    output logic                    cycle_complete,
    output logic [3:0]              component_index,
    output logic [1:0]              transport_mode,
    output logic [5:0]              component_type,
    output logic [5:0]              subchannel_id,
    output logic                    secondary_flag,
    output logic                    ca_flag
);
    import dsc_pkg::*;

    // Input register: one byte waiting to be parsed.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       long_reg;

    // Output register: one finished record waiting for the receiver.
    logic       out_valid_reg, out_valid_next;
    rec_t       rec_reg;

    logic       advance;
    logic       res_valid;
    rec_t       res;
    seen_ctl_t  seen_ctl;
    logic       hit;

    // Parse the held byte only while the output register is free or emptying.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (advance && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; the valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= byte_value;
            start_reg <= start_of_field;
            long_reg  <= long_ids;
        end
        if (advance && res_valid)
        begin
            rec_reg <= res;
        end
    end

    dsc_field_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .byte_value     (byte_reg),
        .start_of_field (start_reg),
        .long_ids       (long_reg),
        .hit            (hit),
        .res_valid      (res_valid),
        .res            (res),
        .seen_ctl       (seen_ctl)
    );

    dsc_seen_table u_seen (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (seen_ctl),
        .hit   (hit)
    );

    assign out_valid       = out_valid_reg;
    assign record_kind     = rec_reg.record_kind;
    assign service_id      = rec_reg.service_id;
    assign local_flag      = rec_reg.local_flag;
    assign access_id       = rec_reg.access_id;
    assign component_count = rec_reg.component_count;
    assign cycle_complete  = rec_reg.cycle_complete;
    assign component_index = rec_reg.component_index;
    assign transport_mode  = rec_reg.transport_mode;
    assign component_type  = rec_reg.component_type;
    assign subchannel_id   = rec_reg.subchannel_id;
    assign secondary_flag  = rec_reg.secondary_flag;
    assign ca_flag         = rec_reg.ca_flag;

endmodule

[rtl/core/dsc_checker.sv]
// Port-level checks of the parser core and their binding.
`include "assert_macros.svh"

module dsc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       record_kind,
    input logic       local_flag,
    input logic [2:0] access_id,
    input logic [3:0] component_count,
    input logic       cycle_complete,
    input logic [3:0] component_index,
    input logic [1:0] transport_mode,
    input logic [5:0] component_type,
    input logic [5:0] subchannel_id,
    input logic       secondary_flag,
    input logic       ca_flag
);
    import dsc_pkg::*;

    `DSC_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_n |-> !out_valid, "out_valid high in reset")

    `DSC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "stalled record dropped")

    `DSC_ASSERT(a_service_clean, (out_valid && record_kind == RK_SERVICE) |-> (component_index == 4'd0 && transport_mode == 2'd0 && component_type == 6'd0 && subchannel_id == 6'd0 && !secondary_flag && !ca_flag), "service record carries component fields")

    `DSC_ASSERT(a_component_clean, (out_valid && record_kind == RK_COMPONENT) |-> (!local_flag && access_id == 3'd0 && component_count == 4'd0 && !cycle_complete), "component record carries service fields")

    `DSC_ASSERT(a_index_range, (out_valid && record_kind == RK_COMPONENT) |-> (component_index != 4'hF), "component index out of range")

endmodule

bind dab_service_component_parser_core dsc_checker u_dsc_checker (.*);
